[sv/pwt_pkg.sv]
// Package: shared types, constants and helpers of the windowed-trapezoid PID block.
`default_nettype none
package pwt_pkg;
  localparam int WINDOW_DEPTH = 512;
  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int WIN_W = 10;
  localparam int NUM_REGS = 7;

  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_OUT_MAX = 3'd4;
  localparam logic [2:0] REG_OUT_MIN = 3'd5;
  localparam logic [2:0] REG_WINDOW_LEN = 3'd6;

  localparam logic [WIN_W-1:0] WINDOW_LEN_RST = WIN_W'(350);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_AREA, ST_SUM, ST_DIV, ST_SLOPE,
    ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_DRIVE, ST_OUT
  } pwt_state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_req_t;
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/pwt_ring.sv]
// Area ring store: one synchronous RAM with a registered read port.
`default_nettype none
module pwt_ring
  import pwt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [PTR_W-1:0]  waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [PTR_W-1:0]  raddr,
  output logic [31:0]            rdata
);
  logic [31:0] mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/pwt_div.sv]
// Restoring divider: |diff| * 2^16 / dt, one quotient bit per cycle.
`default_nettype none
module pwt_div
  import pwt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire div_req_t    req,
  input  wire logic [32:0] dividend_mag, // |diff|, up to 2^32 - 1
  input  wire logic [15:0] divisor,
  output div_stat_t        stat,
  output logic [48:0]      quotient
);
  localparam int QW = 49;
  logic [QW-1:0] num_r, num_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[15:0], num_r[QW-1]};
    if (req.start) begin
      num_nxt = {dividend_mag, 16'd0};
      rem_nxt = '0;
      cnt_nxt = 6'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        num_nxt = {num_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient = num_r;
endmodule
`default_nettype wire

[sv/pid_windowed_trapezoid.sv]
// Top level: PID step sequencer around the area ring RAM and the slope divider.
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tdata: measurement[31:0], delta_time[47:32]
//  out_    | out | tdata: drive[31:0], p_term[63:32], i_term[95:64], d_term[127:96]
//  cfg_    | in  | index 0..6 = gain_p, gain_i, gain_d, setpoint, out_max, out_min, window_len
//
// An item runs from one input transfer to the next through READ, AREA, SUM, DIV, SLOPE,
// MUL_P, MUL_I, MUL_D, DRIVE and OUT; DIV waits on the 49-step slope divider when the
// error changes with a nonzero delta_time; multiplies share one 48x24 product.
// After reset a clearing pass writes 512 zero entries into the ring, during which
// in_tready is low. A result waits in the output register while the next item is
// taken; the step then stalls at its end until the register is free.
`default_nettype none
module pid_windowed_trapezoid
  import pwt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,  // measurement[31:0], delta_time[47:32]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata, // drive, p_term, i_term, d_term
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  // configuration registers
  logic signed [23:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [31:0] setpoint_r, out_max_r, out_min_r;
  logic [WIN_W-1:0] window_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0; gain_i_r <= '0; gain_d_r <= '0;
      setpoint_r <= '0;
      out_max_r <= 32'sh7fffffff;
      out_min_r <= 32'sh80000000;
      window_len_r <= WINDOW_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_wdata[23:0];
        REG_GAIN_I: gain_i_r <= cfg_wdata[23:0];
        REG_GAIN_D: gain_d_r <= cfg_wdata[23:0];
        REG_SETPOINT: setpoint_r <= cfg_wdata;
        REG_OUT_MAX: out_max_r <= cfg_wdata;
        REG_OUT_MIN: out_min_r <= cfg_wdata;
        REG_WINDOW_LEN: window_len_r <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  pwt_state_t st_r, st_nxt;
  logic signed [31:0] last_error_r, last_slope_r;
  logic signed [47:0] integral_r;
  logic [PTR_W-1:0] pos_r, clr_r;
  logic signed [31:0] err_r, meas_r;
  logic [15:0] dt_r;
  logic signed [31:0] area_r;
  logic signed [31:0] pt_r, it_r, dt_term_r;
  logic out_valid_r;
  logic [127:0] out_data_r;

  // ring
  logic ring_we;
  logic [PTR_W-1:0] ring_waddr, ring_raddr;
  logic [31:0] ring_wdata, ring_rdata;
  logic [WIN_W-1:0] win_eff;

  assign win_eff = (window_len_r > WIN_W'(WINDOW_DEPTH)) ? WIN_W'(WINDOW_DEPTH) : window_len_r;
  assign ring_raddr = pos_r - win_eff[PTR_W-1:0];
  assign ring_we = (st_r == ST_CLEAR) || (st_r == ST_SUM);
  assign ring_waddr = (st_r == ST_CLEAR) ? clr_r : pos_r;
  assign ring_wdata = (st_r == ST_CLEAR) ? 32'd0 : area_r;

  pwt_ring u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  // divider
  div_req_t div_req;
  div_stat_t div_stat;
  logic [48:0] quo;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  assign diff = 33'(err_r) - 33'(last_error_r);
  assign diff_mag = diff[32] ? 33'(-diff) : diff;
  assign div_req.start = (st_r == ST_AREA) && (err_r != last_error_r) && (dt_r != 16'd0);

  pwt_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .dividend_mag(diff_mag),
    .divisor(dt_r), .stat(div_stat), .quotient(quo)
  );

  // shared multiplier: floor(value * gain / 2^12), saturated
  // operands are picked one state ahead of the state that stores the term
  logic signed [47:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [71:0] prod_r;
  logic signed [59:0] prod_sh;
  always_comb begin
    unique case (st_r)
      ST_SLOPE: begin mul_a = 48'(err_r); mul_b = gain_p_r; end
      ST_MUL_P: begin mul_a = integral_r; mul_b = gain_i_r; end
      default: begin mul_a = 48'(last_slope_r); mul_b = gain_d_r; end
    endcase
  end
  assign prod_sh = prod_r[71:12];

  logic signed [33:0] drive_sum;
  logic signed [33:0] drive_hi;
  assign drive_sum = 34'(pt_r) + 34'(it_r) + 34'(dt_term_r);
  always_comb begin
    drive_hi = drive_sum;
    if (drive_hi > 34'(out_max_r)) drive_hi = 34'(out_max_r);
    if (drive_hi < 34'(out_min_r)) drive_hi = 34'(out_min_r);
  end

  logic signed [49:0] sum_w;
  logic signed [48:0] area_prod;
  assign area_prod = (49'(last_error_r) + 49'(err_r)) * $signed({1'b0, dt_r});

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == PTR_W'(WINDOW_DEPTH - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (in_tvalid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_AREA;
      ST_AREA: st_nxt = ST_SUM;
      ST_SUM: st_nxt = ST_DIV;
      ST_DIV: if (!div_stat.busy) st_nxt = ST_SLOPE;
      ST_SLOPE: st_nxt = ST_MUL_P;
      ST_MUL_P: st_nxt = ST_MUL_I;
      ST_MUL_I: st_nxt = ST_MUL_D;
      ST_MUL_D: st_nxt = ST_DRIVE;
      ST_DRIVE: st_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign in_tready = (st_r == ST_IDLE);

  always_comb begin
    sum_w = 50'(integral_r) + 50'(area_r);
    if (win_eff != '0) sum_w = sum_w - 50'($signed(ring_rdata));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      pos_r <= '0;
      last_error_r <= '0;
      last_slope_r <= '0;
      integral_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + PTR_W'(1);
      // ST_OUT reloads the register itself in the cycle it drains
      if (out_valid_r && out_tready && st_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_tvalid) begin
          meas_r <= in_tdata[31:0];
          dt_r <= in_tdata[47:32];
        end
        ST_READ: err_r <= sat32(64'(setpoint_r) - 64'(meas_r));
        ST_AREA: area_r <= 32'(area_prod >>> 17);
        ST_SUM: begin
          if (sum_w > 50'sh7fffffffffff) integral_r <= 48'sh7fffffffffff;
          else if (sum_w < -50'sh800000000000) integral_r <= 48'sh800000000000;
          else integral_r <= sum_w[47:0];
          pos_r <= pos_r + PTR_W'(1);
        end
        ST_SLOPE: begin
          if (err_r != last_error_r) begin
            if (dt_r == 16'd0)
              last_slope_r <= diff[32] ? 32'sh80000000 : 32'sh7fffffff;
            else if (diff[32])
              last_slope_r <= sat32(-64'({15'd0, quo}));
            else
              last_slope_r <= sat32(64'({15'd0, quo}));
          end
          last_error_r <= err_r;
          prod_r <= mul_a * mul_b;
        end
        ST_MUL_P: begin
          pt_r <= sat32(64'(prod_sh));
          prod_r <= mul_a * mul_b;
        end
        ST_MUL_I: begin
          it_r <= sat32(64'(prod_sh));
          prod_r <= mul_a * mul_b;
        end
        ST_MUL_D: dt_term_r <= sat32(64'(prod_sh));
        ST_DRIVE: ;
        ST_OUT: if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_data_r <= {dt_term_r, it_r, pt_r, drive_hi[31:0]};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule
`default_nettype wire

[sv/pwt_checker.sv]
// Port-level checker for the PID block, bound to the top level.
`default_nettype none
module pwt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // no input taken in the cycle after a transfer in
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken at once");
  // no result right after an input transfer
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");
  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind pid_windowed_trapezoid pwt_checker u_pwt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

[dv/tb.sv]
// Testbench for pid_windowed_trapezoid: directed table plus random steps, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pwt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;   // measurement[31:0], delta_time[47:32]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;      // drive, p_term, i_term, d_term
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_GAIN_P;
  logic [31:0] cfg_wdata = '0;

  pid_windowed_trapezoid dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  typedef struct packed {
    logic signed [31:0] d_term;
    logic signed [31:0] i_term;
    logic signed [31:0] p_term;
    logic signed [31:0] drive;
  } pid_out_t;

  // controller model state
  logic signed [23:0] kp, ki, kd;
  logic signed [31:0] sp_q, omax_q, omin_q;
  logic [9:0] win_q;
  longint prev_err, prev_slope, integ;
  longint areas [WINDOW_DEPTH];
  int wr_pos;

  pid_out_t pending_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit all_sent = 1'b0;
  bit hold_off = 1'b0;
  localparam longint CYCLE_LIMIT = 2000000;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // floor(v * g / 4096), saturated; split so the product stays in 64 bits
  function automatic longint gain_mul(longint v, longint g);
    longint h, l;
    h = v >>> 12;
    l = v - h * 4096;
    return clip(h * g + ((l * g) >>> 12), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic pid_out_t pid_step(logic signed [31:0] meas, logic [15:0] dt);
    longint e, area, s, diff, w, sum;
    pid_out_t r;
    e = clip(longint'(sp_q) - longint'(meas), -64'sd2147483648, 64'sd2147483647);
    area = ((prev_err + e) * longint'(dt)) >>> 17;
    w = (win_q > WINDOW_DEPTH) ? WINDOW_DEPTH : win_q;
    if (w > 0) s = integ - areas[(wr_pos + WINDOW_DEPTH - w) % WINDOW_DEPTH] + area;
    else s = integ + area;
    integ = clip(s, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    areas[wr_pos] = area;
    wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
    if (e != prev_err) begin
      diff = e - prev_err;
      if (dt == 0) prev_slope = diff > 0 ? 64'sd2147483647 : -64'sd2147483648;
      else prev_slope = clip((diff * 65536) / longint'(dt),
                             -64'sd2147483648, 64'sd2147483647);
    end
    prev_err = e;
    r.p_term = gain_mul(e, kp);
    r.i_term = gain_mul(integ, ki);
    r.d_term = gain_mul(prev_slope, kd);
    sum = longint'(r.p_term) + longint'(r.i_term) + longint'(r.d_term);
    if (sum > omax_q) sum = omax_q;
    if (sum < omin_q) sum = omin_q;
    r.drive = sum[31:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN_P: kp = val[23:0];
      REG_GAIN_I: ki = val[23:0];
      REG_GAIN_D: kd = val[23:0];
      REG_SETPOINT: sp_q = val;
      REG_OUT_MAX: omax_q = val;
      REG_OUT_MIN: omin_q = val;
      default: win_q = val[9:0];
    endcase
  endtask

  // wait until every step has reported, plus slack for a step still running
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // one transfer in; check_exp set means the typed expectation replaces the prediction
  task automatic send_step(logic [31:0] meas, logic [15:0] dt, bit use_gap,
                           bit check_exp, pid_out_t exp_r);
    pid_out_t p;
    if (use_gap && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 4))
        @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {dt, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = pid_step(meas, dt);
    pending_q.push_back(check_exp ? exp_r : p);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 200000) - 100000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    pid_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected drive %h p %h i %h d %h, got %h %h %h %h",
                     want.drive, want.p_term, want.i_term, want.d_term,
                     got.drive, got.p_term, got.i_term, got.d_term);
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_tready <= 1'b1;
    else if (!out_tready) out_tready <= ($urandom_range(0, 3) != 0);
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (all_sent == 1'b0 && rst_n);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    logic [31:0] meas;
    logic [15:0] dt;
    bit has_exp;
    pid_out_t exp_r;
  } step_row_t;

  initial begin
    step_row_t rows[$];
    logic [31:0] cur_meas;
    int n;
    kp = 0; ki = 0; kd = 0; sp_q = 0;
    omax_q = 32'h7fffffff; omin_q = 32'h80000000; win_q = 10'd350;
    prev_err = 0; prev_slope = 0; integ = 0; wr_pos = 0;
    foreach (areas[k]) areas[k] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset all gains are zero: every output is zero
    rows.push_back('{32'h0001_0000, 16'h8000, 1'b1, '0});
    rows.push_back('{32'h8000_0000, 16'h0000, 1'b1, '0});
    foreach (rows[k]) send_step(rows[k].meas, rows[k].dt, 1'b0, rows[k].has_exp, rows[k].exp_r);
    drain();

    // unit P and I gains, small D gain, short window, crossed clamps then extremes
    write_reg(REG_GAIN_P, 32'h001000);
    write_reg(REG_GAIN_I, 32'h001000);
    write_reg(REG_GAIN_D, 32'h000100);
    write_reg(REG_SETPOINT, 32'h0002_0000);
    write_reg(REG_WINDOW_LEN, 10'd3);
    rows.delete();
    rows.push_back('{32'h7fffffff, 16'hffff, 1'b0, '0});
    rows.push_back('{32'h7fffffff, 16'hffff, 1'b0, '0});  // unchanged error keeps slope
    rows.push_back('{32'h80000000, 16'h0000, 1'b0, '0});  // zero dt, error changes
    rows.push_back('{32'h80000000, 16'h0001, 1'b0, '0});
    rows.push_back('{32'h0000_0000, 16'h0001, 1'b0, '0});
    rows.push_back('{32'hffff_0000, 16'hffff, 1'b0, '0});
    rows.push_back('{32'h0001_8000, 16'h1234, 1'b0, '0});
    foreach (rows[k]) send_step(rows[k].meas, rows[k].dt, 1'b1, rows[k].has_exp, rows[k].exp_r);
    drain();
    write_reg(REG_OUT_MAX, 32'hffff_0000);
    write_reg(REG_OUT_MIN, 32'h0001_0000);   // crossed: drive pinned at out_min
    write_reg(REG_WINDOW_LEN, 10'd1023);     // above store depth
    write_reg(REG_GAIN_P, 32'h7fffff);
    write_reg(REG_GAIN_I, 32'h800000);
    write_reg(REG_GAIN_D, 32'h800000);
    write_reg(REG_SETPOINT, 32'h8000_0000);
    for (int k = 0; k < 8; k++)
      send_step(k[0] ? 32'h7fffffff : 32'h8000_0000, k[1] ? 16'hffff : 16'd0, 1'b1, 1'b0, '0);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_GAIN_P, ph == 0 ? 32'h800000 : $urandom());
      write_reg(REG_GAIN_I, $urandom_range(0, 3) == 0 ? 32'h7fffff : $urandom());
      write_reg(REG_GAIN_D, $urandom());
      write_reg(REG_SETPOINT, rand_val());
      write_reg(REG_OUT_MAX, $urandom_range(0, 2) == 0 ? 32'h7fffffff : $urandom());
      write_reg(REG_OUT_MIN, $urandom_range(0, 2) == 0 ? 32'h80000000 : $urandom());
      case (ph % 5)
        0: write_reg(REG_WINDOW_LEN, 10'd0);
        1: write_reg(REG_WINDOW_LEN, 10'd512);
        2: write_reg(REG_WINDOW_LEN, 10'd1);
        default: write_reg(REG_WINDOW_LEN, $urandom_range(0, 1023));
      endcase
      n = 125;
      cur_meas = rand_val();
      for (int k = 0; k < n; k++) begin
        // mostly slowly drifting measurements, sometimes held, sometimes jumps
        case ($urandom_range(0, 5))
          0: cur_meas = rand_val();
          1: ;
          default: cur_meas = cur_meas + $urandom_range(0, 4000) - 2000;
        endcase
        send_step(cur_meas, rand_dt(), ph % 4 != 3, 1'b0, '0);
      end
      drain();
    end

    all_sent = 1'b1;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // leftover expectations are caught by drain before the verdict
endmodule
`default_nettype wire
